[src/icr_pkg.sv]
// Shared types, codes and the source map of the interrupt controller registers.
package icr_pkg;

   localparam logic [2:0] CMD_READ  = 3'd0;
   localparam logic [2:0] CMD_WRITE = 3'd1;
   localparam logic [2:0] CMD_RAISE = 3'd2;
   localparam logic [2:0] CMD_EVAL  = 3'd3;
   localparam logic [2:0] CMD_GATE  = 3'd4;

   localparam logic [7:0] ADDR_PRIO_1   = 8'h20;
   localparam logic [7:0] ADDR_PRIO_2   = 8'h21;
   localparam logic [7:0] ADDR_PRIO_3   = 8'h22;
   localparam logic [7:0] ADDR_ENABLE_1 = 8'h23;
   localparam logic [7:0] ADDR_ENABLE_2 = 8'h24;
   localparam logic [7:0] ADDR_ENABLE_3 = 8'h25;
   localparam logic [7:0] ADDR_ENABLE_4 = 8'h26;
   localparam logic [7:0] ADDR_ACTIVE_1 = 8'h27;
   localparam logic [7:0] ADDR_ACTIVE_2 = 8'h28;
   localparam logic [7:0] ADDR_ACTIVE_3 = 8'h29;
   localparam logic [7:0] ADDR_ACTIVE_4 = 8'h2A;

   localparam logic [7:0] MASK_PRIO_3 = 8'h03;
   localparam logic [7:0] MASK_BANK_2 = 8'h3F;
   localparam logic [7:0] MASK_BANK_4 = 8'hF7;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] reg_addr;
      logic [7:0] write_data;
      logic [4:0] source_id;
      logic       gate_value;
   } icr_item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_valid;
      logic [4:0] irq_vector;
   } icr_result_type;

   typedef struct packed {
      logic [2:0][7:0] prio;
      logic [3:0][7:0] enable_bank;
      logic [3:0][7:0] active_bank;
      logic            master_gate;
   } icr_state_type;

   typedef struct packed {
      logic       raisable;
      logic [1:0] prio_sel;
      logic [7:0] prio_mask;
      logic [1:0] bank;
      logic [7:0] bit_mask;
   } icr_src_type;

   // per vector: priority field, bank and bit; vectors ascend in scan order
   function automatic icr_src_type src_info(logic [4:0] v);
      icr_src_type s;
      s = '{raisable: 1'b0, prio_sel: 2'd0, prio_mask: 8'h00, bank: 2'd0, bit_mask: 8'h00};
      case (v)
         5'd3:  s = '{1'b1, 2'd0, 8'hC0, 2'd0, 8'h80};
         5'd4:  s = '{1'b1, 2'd0, 8'hC0, 2'd0, 8'h40};
         5'd5:  s = '{1'b1, 2'd0, 8'h30, 2'd0, 8'h20};
         5'd6:  s = '{1'b1, 2'd0, 8'h30, 2'd0, 8'h10};
         5'd7:  s = '{1'b1, 2'd0, 8'h0C, 2'd0, 8'h08};
         5'd8:  s = '{1'b1, 2'd0, 8'h0C, 2'd0, 8'h04};
         5'd9:  s = '{1'b1, 2'd0, 8'h03, 2'd0, 8'h02};
         5'd10: s = '{1'b1, 2'd0, 8'h03, 2'd0, 8'h01};
         5'd11: s = '{1'b1, 2'd1, 8'hC0, 2'd1, 8'h20};
         5'd12: s = '{1'b1, 2'd1, 8'hC0, 2'd1, 8'h10};
         5'd13: s = '{1'b1, 2'd1, 8'hC0, 2'd1, 8'h08};
         5'd14: s = '{1'b1, 2'd1, 8'hC0, 2'd1, 8'h04};
         5'd15: s = '{1'b1, 2'd2, 8'h03, 2'd3, 8'h80};
         5'd16: s = '{1'b1, 2'd2, 8'h03, 2'd3, 8'h40};
         5'd19: s = '{1'b1, 2'd1, 8'h30, 2'd1, 8'h02};
         5'd20: s = '{1'b1, 2'd1, 8'h30, 2'd1, 8'h01};
         5'd21: s = '{1'b1, 2'd1, 8'h0C, 2'd2, 8'h80};
         5'd22: s = '{1'b1, 2'd1, 8'h0C, 2'd2, 8'h40};
         5'd23: s = '{1'b1, 2'd1, 8'h0C, 2'd2, 8'h20};
         5'd24: s = '{1'b1, 2'd1, 8'h0C, 2'd2, 8'h10};
         5'd25: s = '{1'b1, 2'd1, 8'h0C, 2'd2, 8'h08};
         5'd26: s = '{1'b1, 2'd1, 8'h0C, 2'd2, 8'h04};
         5'd27: s = '{1'b1, 2'd1, 8'h0C, 2'd2, 8'h02};
         5'd28: s = '{1'b1, 2'd1, 8'h0C, 2'd2, 8'h01};
         5'd29: s = '{1'b0, 2'd1, 8'h03, 2'd3, 8'h04};
         5'd30: s = '{1'b0, 2'd1, 8'h03, 2'd3, 8'h02};
         5'd31: s = '{1'b0, 2'd1, 8'h03, 2'd3, 8'h01};
         default: s = '{raisable: 1'b0, prio_sel: 2'd0, prio_mask: 8'h00,
                        bank: 2'd0, bit_mask: 8'h00};
      endcase
      return s;
   endfunction

endpackage

[src/icr_irq_scan.sv]
// Priority scan: first enabled active source with a priority, gate open.
module icr_irq_scan (
   input  icr_pkg::icr_state_type state,
   output logic                   irq_valid,
   output logic [4:0]             irq_vector
);

   logic [31:0] hits;

   always_comb begin
      icr_pkg::icr_src_type s;
      for (int v = 0; v < 32; v++) begin
         s = icr_pkg::src_info(5'(v));
         hits[v] = state.master_gate
                   && ((state.prio[s.prio_sel] & s.prio_mask) != 8'h00)
                   && ((state.enable_bank[s.bank] & state.active_bank[s.bank]
                        & s.bit_mask) != 8'h00);
      end
   end

   // lowest vector wins
   always_comb begin
      irq_vector = 5'd0;
      for (int v = 31; v >= 0; v--) begin
         if (hits[v]) begin
            irq_vector = 5'(v);
         end
      end
      irq_valid = (hits != 32'd0);
   end

endmodule

[src/icr_reg_file.sv]
// Register bank: command decode, state update and result forming.
module icr_reg_file (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    update,
   input  icr_pkg::icr_item_type   item,
   output icr_pkg::icr_result_type result
);

   icr_pkg::icr_state_type state_ff;
   icr_pkg::icr_state_type state_in;
   logic                   eval_req;
   logic [7:0]             rd_data;
   logic                   scan_valid;
   logic [4:0]             scan_vector;
   icr_pkg::icr_src_type   raise_src;

   assign raise_src = icr_pkg::src_info(item.source_id);

   always_comb begin
      state_in = state_ff;
      eval_req = 1'b0;
      rd_data  = 8'h00;
      case (item.cmd)
         icr_pkg::CMD_READ: begin
            case (item.reg_addr)
               icr_pkg::ADDR_PRIO_1:   rd_data = state_ff.prio[0];
               icr_pkg::ADDR_PRIO_2:   rd_data = state_ff.prio[1];
               icr_pkg::ADDR_PRIO_3:   rd_data = state_ff.prio[2] & icr_pkg::MASK_PRIO_3;
               icr_pkg::ADDR_ENABLE_1: rd_data = state_ff.enable_bank[0];
               icr_pkg::ADDR_ENABLE_2: rd_data = state_ff.enable_bank[1] & icr_pkg::MASK_BANK_2;
               icr_pkg::ADDR_ENABLE_3: rd_data = state_ff.enable_bank[2];
               icr_pkg::ADDR_ENABLE_4: rd_data = state_ff.enable_bank[3] & icr_pkg::MASK_BANK_4;
               icr_pkg::ADDR_ACTIVE_1: rd_data = state_ff.active_bank[0];
               icr_pkg::ADDR_ACTIVE_2: rd_data = state_ff.active_bank[1] & icr_pkg::MASK_BANK_2;
               icr_pkg::ADDR_ACTIVE_3: rd_data = state_ff.active_bank[2];
               icr_pkg::ADDR_ACTIVE_4: rd_data = state_ff.active_bank[3] & icr_pkg::MASK_BANK_4;
               default:                rd_data = 8'h00;
            endcase
         end
         icr_pkg::CMD_WRITE: begin
            case (item.reg_addr)
               icr_pkg::ADDR_PRIO_1: begin
                  state_in.prio[0] = item.write_data;
                  eval_req = 1'b1;
               end
               icr_pkg::ADDR_PRIO_2: begin
                  state_in.prio[1] = item.write_data;
                  eval_req = 1'b1;
               end
               icr_pkg::ADDR_PRIO_3: begin
                  state_in.prio[2] = item.write_data;
                  eval_req = 1'b1;
               end
               icr_pkg::ADDR_ENABLE_1: begin
                  state_in.enable_bank[0] = item.write_data;
                  eval_req = 1'b1;
               end
               icr_pkg::ADDR_ENABLE_2: begin
                  state_in.enable_bank[1] = item.write_data & icr_pkg::MASK_BANK_2;
                  eval_req = 1'b1;
               end
               icr_pkg::ADDR_ENABLE_3: begin
                  state_in.enable_bank[2] = item.write_data;
                  eval_req = 1'b1;
               end
               icr_pkg::ADDR_ENABLE_4: begin
                  state_in.enable_bank[3] = item.write_data & icr_pkg::MASK_BANK_4;
                  eval_req = 1'b1;
               end
               // write one to clear
               icr_pkg::ADDR_ACTIVE_1:
                  state_in.active_bank[0] = state_ff.active_bank[0] & ~item.write_data;
               icr_pkg::ADDR_ACTIVE_2:
                  state_in.active_bank[1] = state_ff.active_bank[1] & ~item.write_data;
               icr_pkg::ADDR_ACTIVE_3:
                  state_in.active_bank[2] = state_ff.active_bank[2] & ~item.write_data;
               icr_pkg::ADDR_ACTIVE_4:
                  state_in.active_bank[3] = state_ff.active_bank[3] & ~item.write_data;
               default: begin
                  state_in = state_ff;
               end
            endcase
         end
         icr_pkg::CMD_RAISE: begin
            if (raise_src.raisable) begin
               state_in.active_bank[raise_src.bank] =
                  state_ff.active_bank[raise_src.bank] | raise_src.bit_mask;
            end
         end
         icr_pkg::CMD_EVAL: begin
            eval_req = 1'b1;
         end
         icr_pkg::CMD_GATE: begin
            state_in.master_gate = item.gate_value;
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

   // scan sees the state after this word's write
   icr_irq_scan u_scan (
      .state      (state_in),
      .irq_valid  (scan_valid),
      .irq_vector (scan_vector)
   );

   always_comb begin
      result.read_data  = rd_data;
      result.irq_valid  = eval_req & scan_valid;
      result.irq_vector = eval_req ? scan_vector : 5'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{prio: '0, enable_bank: '0, active_bank: '0, master_gate: 1'b1};
      end else if (update) begin
         state_ff <= state_in;
      end
   end

endmodule

[src/interrupt_controller_regs.sv]
// Top level of the interrupt controller registers: stream ports, input and result registers.
// An accepted req word is held in the input register, then in the result register, which drives its rsp word.
// Throughput: one word per clock while rsp_tready is high; the single-pass decode and priority
// scan sit between the input and result registers; state is updated as a word enters the result.
// Reset (synchronous, active high): both registers empty, priority, enable and active
// registers cleared, master gate set.
module interrupt_controller_regs (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [icr_pkg::REQ_DATA_W-1:0] req_tdata,  // reg_addr, write_data, source_id, gate_value
   input  logic [2:0]                     req_tuser,  // cmd
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [icr_pkg::RSP_DATA_W-1:0] rsp_tdata   // read_data, irq_valid, irq_vector
);

   logic                    in_valid_ff;
   logic                    in_valid_in;
   icr_pkg::icr_item_type   in_item_ff;
   icr_pkg::icr_item_type   in_item_in;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   icr_pkg::icr_result_type out_result_ff;
   icr_pkg::icr_result_type out_result_in;
   icr_pkg::icr_result_type result;
   logic                    out_free;
   logic                    advance;
   logic                    req_fire;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_item_in.cmd        = req_tuser;
      in_item_in.reg_addr   = req_tdata[7:0];
      in_item_in.write_data = req_tdata[15:8];
      in_item_in.source_id  = req_tdata[20:16];
      in_item_in.gate_value = req_tdata[21];

      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
      out_result_in = advance ? result : out_result_ff;
   end

   icr_reg_file u_reg_file (
      .clock  (clock),
      .reset  (reset),
      .update (advance),
      .item   (in_item_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= in_item_in;
      end
      out_result_ff <= out_result_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_result_ff.irq_vector, out_result_ff.irq_valid,
                        out_result_ff.read_data};

   a_vec_matches_valid: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_result_ff.irq_valid == (out_result_ff.irq_vector != 5'd0)))
      else $error("irq_valid and irq_vector disagree");

   a_read_only_data: assert property (@(posedge clock) disable iff (reset)
      advance && (in_item_ff.cmd != icr_pkg::CMD_READ) |=> out_result_ff.read_data == 8'h00)
      else $error("read_data nonzero on a non-read word");

   a_raise_no_irq: assert property (@(posedge clock) disable iff (reset)
      advance && ((in_item_ff.cmd == icr_pkg::CMD_RAISE) || (in_item_ff.cmd == icr_pkg::CMD_GATE))
      |=> !out_result_ff.irq_valid)
      else $error("irq reported on raise or gate word");

   a_held_word_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("input word dropped while stalled");

endmodule
